>>> hw/rtl/sorted_priority_queue_macros.svh
// sorted_priority_queue_macros.svh
// assertion macros for the sorted priority queue checker
// depends on clk and arst_n being visible where a macro is used

`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/spq_pkg.sv
// spq_pkg.sv
// shared types and codes for the sorted priority queue
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

	// fixed field widths of the channels
	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 16;
	localparam int COUNT_W  = 5;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/spq_if.sv
// spq_if.sv
// valid/ready channel interfaces for commands and results
// depends on spq_pkg
`timescale 1ns / 1ps

interface spq_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [spq_pkg::OP_W-1:0]          operation;
	logic [spq_pkg::VALUE_W-1:0]       item_value;
	logic signed [spq_pkg::PRIO_W-1:0] item_priority;

	modport source (output valid, output operation, output item_value,
		output item_priority, input ready);
	modport sink (input valid, input operation, input item_value,
		input item_priority, output ready);
endinterface

interface spq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [spq_pkg::VALUE_W-1:0]       popped_value;
	logic [spq_pkg::STATUS_W-1:0]      status;
	logic [spq_pkg::COUNT_W-1:0]       entry_count;
	logic                              queue_empty;
	logic signed [spq_pkg::PRIO_W-1:0] next_priority;

	modport source (output valid, output popped_value, output status,
		output entry_count, output queue_empty, output next_priority, input ready);
	modport sink (input valid, input popped_value, input status,
		input entry_count, input queue_empty, input next_priority, output ready);
endinterface

>>> hw/rtl/spq_cell.sv
// spq_cell.sv
// one slot of the sorted chain: holds a value and priority, shifts or inserts
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell #(
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 16
) (
	input  logic                             clk,
	input  spq_pkg::cell_ctrl_t              ctrl,
	input  logic                             occupied,
	input  logic [VALUE_WIDTH-1:0]           new_value,
	input  logic signed [PRIORITY_WIDTH-1:0] new_priority,
	input  logic                             left_keep,
	input  logic [VALUE_WIDTH-1:0]           left_value,
	input  logic signed [PRIORITY_WIDTH-1:0] left_priority,
	input  logic [VALUE_WIDTH-1:0]           right_value,
	input  logic signed [PRIORITY_WIDTH-1:0] right_priority,
	output logic                             keep,
	output logic [VALUE_WIDTH-1:0]           value,
	output logic signed [PRIORITY_WIDTH-1:0] priority_q
);
	import spq_pkg::*;

	logic [VALUE_WIDTH-1:0] value_q;

	// entry stays put when it leaves no later than the newcomer (ties stay ahead)
	assign keep  = occupied && (priority_q <= new_priority);
	assign value = value_q;

	// insert in place, or take the neighbour's entry
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!keep) begin
				if (left_keep) begin
					value_q    <= new_value;
					priority_q <= new_priority;
				end else begin
					value_q    <= left_value;
					priority_q <= left_priority;
				end
			end
		end else if (ctrl.pop) begin
			value_q    <= right_value;
			priority_q <= right_priority;
		end
	end

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// sorted_priority_queue.sv
// top level: command decode, fill count, result register and the cell chain
// depends on spq_pkg, spq_if, spq_cell
`timescale 1ns / 1ps

// channel | dir | fields
// cmd     | in  | operation, item_value, item_priority
// rsp     | out | popped_value, status, entry_count, queue_empty, next_priority
//
// one command per cycle while results are taken; its result appears in the register on the next cycle
// each cell decides with one priority compare and a three-way select, in parallel
// reset clears the fill count and the result valid flag; slots need no clearing
// a result held by rsp.ready low stalls cmd until it is taken

module sorted_priority_queue #(
	parameter int DEPTH          = 16,
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	spq_cmd_if.sink   cmd,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                rsp_valid_q;
	logic [VALUE_W-1:0]  popped_q;
	logic [VALUE_W-1:0]  popped_d;
	status_t             status_q;
	status_t             status_d;
	logic                accept;
	op_t                 op;
	cell_ctrl_t          ctrl;

	logic [63:0]                      in_val_wide;
	logic signed [31:0]               in_pri_wide;
	logic [VALUE_WIDTH-1:0]           new_value;
	logic signed [PRIORITY_WIDTH-1:0] new_priority;
	logic [63:0]                      head_val_wide;
	logic signed [31:0]               head_pri_wide;

	logic                             cell_keep [DEPTH];
	logic [VALUE_WIDTH-1:0]           cell_val  [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] cell_pri  [DEPTH];

	// handshake: a new command may enter when no result is held or as the held result leaves
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign op        = op_t'(cmd.operation);

	// fit the incoming fields to the storage widths
	assign in_val_wide  = 64'(cmd.item_value);
	assign in_pri_wide  = 32'(cmd.item_priority);
	assign new_value    = in_val_wide[VALUE_WIDTH-1:0];
	assign new_priority = in_pri_wide[PRIORITY_WIDTH-1:0];

	assign head_val_wide = 64'(cell_val[0]);
	assign head_pri_wide = 32'(cell_pri[0]);

	// command decode
	always_comb begin
		ctrl     = '0;
		count_d  = count_q;
		status_d = ST_OK;
		popped_d = '0;
		case (op)
			OP_PUSH: begin
				if (count_q == CNT_W'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					ctrl.push = accept;
					count_d   = count_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.pop = accept;
					popped_d = head_val_wide[VALUE_W-1:0];
					count_d  = count_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// fill count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			count_q     <= count_d;
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_d;
			status_q <= status_d;
		end
	end

	// state only moves on a transfer, which also reloads the result
	assign rsp.valid         = rsp_valid_q;
	assign rsp.popped_value  = popped_q;
	assign rsp.status        = status_q;
	assign rsp.entry_count   = COUNT_W'(count_q);
	assign rsp.queue_empty   = (count_q == '0);
	assign rsp.next_priority = (count_q == '0) ? '0 : head_pri_wide[PRIO_W-1:0];

	// chain of cells, slot 0 leaves next
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                             l_keep;
		logic [VALUE_WIDTH-1:0]           l_val;
		logic signed [PRIORITY_WIDTH-1:0] l_pri;
		logic [VALUE_WIDTH-1:0]           r_val;
		logic signed [PRIORITY_WIDTH-1:0] r_pri;

		if (i == 0) begin : g_head
			assign l_keep = 1'b1;
			assign l_val  = new_value;
			assign l_pri  = new_priority;
		end else begin : g_mid
			assign l_keep = cell_keep[i-1];
			assign l_val  = cell_val[i-1];
			assign l_pri  = cell_pri[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_val = cell_val[i];
			assign r_pri = cell_pri[i];
		end else begin : g_body
			assign r_val = cell_val[i+1];
			assign r_pri = cell_pri[i+1];
		end

		spq_cell #(
			.VALUE_WIDTH    (VALUE_WIDTH),
			.PRIORITY_WIDTH (PRIORITY_WIDTH)
		) u_cell (
			.clk            (clk),
			.ctrl           (ctrl),
			.occupied       (CNT_W'(i) < count_q),
			.new_value      (new_value),
			.new_priority   (new_priority),
			.left_keep      (l_keep),
			.left_value     (l_val),
			.left_priority  (l_pri),
			.right_value    (r_val),
			.right_priority (r_pri),
			.keep           (cell_keep[i]),
			.value          (cell_val[i]),
			.priority_q     (cell_pri[i])
		);
	end

endmodule

>>> hw/rtl/spq_checker.sv
// spq_checker.sv
// port-level assertions on the sorted priority queue, bound to the top level
// depends on spq_pkg, sorted_priority_queue_macros.svh and sorted_priority_queue
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] popped_value,
	input logic [1:0]  status,
	input logic [4:0]  entry_count,
	input logic        queue_empty,
	input logic [15:0] next_priority
);
	import spq_pkg::*;

	// empty flag agrees with the count
	`SPQ_ASSERT_NOW(a_empty_count, rsp_valid, queue_empty == (entry_count == 5'd0), "empty flag disagrees with count")

	// an empty queue reports a zero priority
	`SPQ_ASSERT_NOW(a_empty_prio, rsp_valid && queue_empty, next_priority == 16'd0, "nonzero priority while empty")

	// a failed operation removes nothing
	`SPQ_ASSERT_NOW(a_fail_zero, rsp_valid && status != ST_OK, popped_value == 32'd0, "value on failed op")

	// a stalled result is held
	`SPQ_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(popped_value) && $stable(entry_count), "result changed under stall")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.popped_value  (rsp.popped_value),
	.status        (rsp.status),
	.entry_count   (rsp.entry_count),
	.queue_empty   (rsp.queue_empty),
	.next_priority (rsp.next_priority)
);

>>> verif/tb_sorted_priority_queue.sv
// tb_sorted_priority_queue.sv
// self-checking testbench for the sorted priority queue: directed and random push, pop, clear
// depends on spq_pkg, spq_if and the sorted_priority_queue rtl
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH    = 16;
	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 6;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int IDLE_PCT       = 11;

	// operation code the block must ignore
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
	localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};

	typedef struct packed {
		logic [VALUE_W-1:0]       value;
		logic signed [PRIO_W-1:0] prio;
	} queue_entry_t;

	typedef struct packed {
		logic [VALUE_W-1:0]       popped_value;
		status_t                  status;
		logic [COUNT_W-1:0]       entry_count;
		logic                     queue_empty;
		logic signed [PRIO_W-1:0] next_priority;
	} queue_result_t;

	logic clk;
	logic arst_n;

	spq_cmd_if cmd_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue #(
		.DEPTH(QUEUE_DEPTH),
		.VALUE_WIDTH(VALUE_W),
		.PRIORITY_WIDTH(PRIO_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// mirror of the queue contents, slot 0 leaves next
	queue_entry_t  held_entries[$];
	queue_result_t awaited_results[$];
	queue_result_t oldest_result;

	int error_count     = 0;
	int quiet_cycles    = 0;
	int sender_idle_pct = IDLE_PCT;
	int receiver_idle_pct = IDLE_PCT;
	bit hold_requested  = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// apply one accepted command to the mirror and queue up the result it should give
	function automatic void apply_queue_op(input logic [OP_W-1:0] op,
		input logic [VALUE_W-1:0] value, input logic signed [PRIO_W-1:0] prio);
		queue_entry_t  entry;
		queue_result_t res;
		int            pos;
		res.popped_value = '0;
		res.status       = ST_OK;
		case (op)
			OP_PUSH: begin
				if (held_entries.size() >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					// new entry goes behind every entry of equal priority
					pos = 0;
					while (pos < held_entries.size() && held_entries[pos].prio <= prio)
						pos++;
					entry.value = value;
					entry.prio  = prio;
					held_entries.insert(pos, entry);
				end
			end
			OP_POP: begin
				if (held_entries.size() == 0) begin
					res.status = ST_EMPTY;
				end else begin
					entry = held_entries.pop_front();
					res.popped_value = entry.value;
				end
			end
			OP_CLEAR: begin
				held_entries.delete();
			end
			default: begin
			end
		endcase
		res.entry_count   = COUNT_W'(held_entries.size());
		res.queue_empty   = (held_entries.size() == 0);
		res.next_priority = (held_entries.size() == 0) ? '0 : held_entries[0].prio;
		awaited_results.push_back(res);
	endfunction

	// check every result transfer, then predict from every command transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no command awaiting it");
					error_count++;
				end else begin
					oldest_result = awaited_results.pop_front();
					if (rsp_ch.popped_value !== oldest_result.popped_value) begin
						$error("popped_value: expected %0h, actual %0h",
							oldest_result.popped_value, rsp_ch.popped_value);
						error_count++;
					end
					if (rsp_ch.status !== oldest_result.status) begin
						$error("status: expected %0d, actual %0d",
							oldest_result.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.entry_count !== oldest_result.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							oldest_result.entry_count, rsp_ch.entry_count);
						error_count++;
					end
					if (rsp_ch.queue_empty !== oldest_result.queue_empty) begin
						$error("queue_empty: expected %0b, actual %0b",
							oldest_result.queue_empty, rsp_ch.queue_empty);
						error_count++;
					end
					if (rsp_ch.next_priority !== oldest_result.next_priority) begin
						$error("next_priority: expected %0d, actual %0d",
							oldest_result.next_priority, rsp_ch.next_priority);
						error_count++;
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				apply_queue_op(cmd_ch.operation, cmd_ch.item_value, cmd_ch.item_priority);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// watchdog on cycles with no transfer on either channel
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("sorted_priority_queue test failed");
		$finish;
	end

	// result receiver: random stalls, plus a long hold-off on request
	initial begin
		int n;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requested) begin
				rsp_ch.ready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_requested = 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
			end
		end
	end

	// offer one command and return at the edge where it is taken
	task automatic send_command(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
		input logic signed [PRIO_W-1:0] prio);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.operation     <= op;
		cmd_ch.item_value    <= value;
		cmd_ch.item_priority <= prio;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	// mostly narrow priorities so that ties are common, some full range and extremes
	function automatic logic signed [PRIO_W-1:0] pick_priority();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return PRIO_W'($urandom_range(0, 6) - 3);
		else if (roll < 90)
			return PRIO_W'($urandom());
		else
			return $urandom_range(0, 1) ? PRIO_MAX : PRIO_MIN;
	endfunction

	// bursts that lean towards filling, draining or neither, with rare clears
	task automatic send_random_burst(input int n_items);
		int               burst_left;
		int               mode;
		int               roll;
		logic [OP_W-1:0]  op;
		burst_left = 0;
		mode       = 0;
		for (int i = 0; i < n_items; i++) begin
			if (burst_left == 0) begin
				mode       = $urandom_range(0, 2);
				burst_left = $urandom_range(8, 40);
			end
			burst_left--;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				op = OP_CLEAR;
			else if (roll < 3)
				op = OP_UNUSED;
			else if (mode == 0)
				op = (roll < 80) ? OP_PUSH : OP_POP;
			else if (mode == 1)
				op = (roll < 25) ? OP_PUSH : OP_POP;
			else
				op = (roll < 52) ? OP_PUSH : OP_POP;
			send_command(op, $urandom(), pick_priority());
		end
	endtask

	// pop, clear and an unused code on an empty queue
	task automatic test_empty_queue();
		send_command(OP_POP, '1, PRIO_MAX);
		send_command(OP_CLEAR, '0, '0);
		send_command(OP_UNUSED, '1, PRIO_MIN);
	endtask

	// fill with extremes and ties, push on full and an unused code, drain a few, clear, pop on empty
	task automatic test_fill_and_overflow();
		logic signed [PRIO_W-1:0] fill_prio [QUEUE_DEPTH] = '{
			5, 5, 5, PRIO_MIN, PRIO_MAX, 0, -1, PRIO_MAX,
			PRIO_MIN, 0, 5, -1, 1, -2, 100, -100};
		logic [VALUE_W-1:0] value;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			value = (i == 0) ? '0 : (i == 1) ? '1 : VALUE_W'(32'h100 + i);
			send_command(OP_PUSH, value, fill_prio[i]);
		end
		send_command(OP_PUSH, 32'hdead_beef, PRIO_MIN);
		send_command(OP_UNUSED, '0, '0);
		for (int i = 0; i < 3; i++)
			send_command(OP_POP, '0, '0);
		send_command(OP_CLEAR, '0, '0);
		send_command(OP_POP, '0, '0);
	endtask

	// receiver holds off for a long stretch while commands keep coming
	task automatic test_backpressure();
		hold_requested = 1'b1;
		send_random_burst(40);
	endtask

	// a long stretch with neither side idling
	task automatic test_no_idle_stretch();
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		send_random_burst(300);
		sender_idle_pct   = IDLE_PCT;
		receiver_idle_pct = IDLE_PCT;
	endtask

	task automatic test_random_mix();
		send_random_burst(1650);
	endtask

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n               <= 1'b0;
		cmd_ch.valid         <= 1'b0;
		cmd_ch.operation     <= OP_PUSH;
		cmd_ch.item_value    <= '0;
		cmd_ch.item_priority <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_fill_and_overflow();
		test_backpressure();
		test_no_idle_stretch();
		test_random_mix();

		cmd_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("sorted_priority_queue test passed");
		else
			$display("sorted_priority_queue test failed");
		$finish;
	end

endmodule
